### hw/rtl/apts_pkg.sv
package apts_pkg;

  // default number of thread slots; the main thread takes the next id
  localparam int MAX_THREADS_DEF = 8;

  localparam int ID_W    = 4;
  localparam int ENTRY_W = 16;
  localparam int ARG_W   = 8;
  localparam int DLY_W   = 8;
  localparam int PRI_W   = 8;
  localparam int ST_W    = 3;
  localparam int MODE_W  = 2;

  // request kinds
  localparam logic [MODE_W-1:0] MODE_SPAWN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXIT  = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_NO_SWITCH = 3'd0;
  localparam logic [ST_W-1:0] ST_SWITCHED  = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_FREE   = 3'd2;
  localparam logic [ST_W-1:0] ST_NONE_RDY  = 3'd3;
  localparam logic [ST_W-1:0] ST_MAIN_EXIT = 3'd4;

  localparam logic [PRI_W-1:0] PRI_MAX = '1;

endpackage

### hw/rtl/aging_priority_thread_scheduler.sv
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// request  | in_valid / in_ready  | mode, entry_point, argument, start_delay
// result   | out_valid / out_ready| status, thread_id, run_entry, run_arg,
//          |                      | run_is_main
//
// One request at a time. A spawn takes a free slot and queues it; a tick, or
// an exit of a spawned thread, walks the queued threads and, on a switch,
// rotates the ready queue to the chosen thread; the walk handles one queue
// entry at a time through the registered reads of the queue and slot memories.
// Synchronous reset clears control state; the result register holds a finished
// result while the next request is taken, and a stalled result stalls the
// following request only at its end.
module aging_priority_thread_scheduler #(
  parameter int MAX_THREADS = apts_pkg::MAX_THREADS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [apts_pkg::MODE_W-1:0]      mode,
  input  logic [apts_pkg::ENTRY_W-1:0]     entry_point,
  input  logic [apts_pkg::ARG_W-1:0]       argument,
  input  logic [apts_pkg::DLY_W-1:0]       start_delay,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [apts_pkg::ST_W-1:0]        status,
  output logic [apts_pkg::ID_W-1:0]        thread_id,
  output logic [apts_pkg::ENTRY_W-1:0]     run_entry,
  output logic [apts_pkg::ARG_W-1:0]       run_arg,
  output logic                             run_is_main
);

  import apts_pkg::*;

  localparam int SW  = $clog2(MAX_THREADS);
  localparam int FCW = $clog2(MAX_THREADS + 1);
  localparam int QD  = MAX_THREADS + 1;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);
  localparam int IW  = ENTRY_W + ARG_W;
  localparam logic [ID_W-1:0] MAIN_ID = ID_W'(MAX_THREADS);

  typedef enum logic [3:0] {
    S_IDLE, S_SP_RD, S_SP_WR, S_W_RDQ, S_W_RDS, S_W_UPD, S_W_END,
    S_ROT_RD, S_ROT_CHK, S_REP_RD, S_REP_OUT
  } state_t;

  state_t state;

  // control registers
  logic [ID_W-1:0]        running_id;
  logic [PRI_W-1:0]       main_prio;
  logic [QAW-1:0]         rq_head;
  logic [QCW-1:0]         rq_cnt;
  logic [SW-1:0]          fl_head;
  logic [FCW-1:0]         fl_cnt;
  logic [MAX_THREADS-1:0] slot_vld;
  logic [MAX_THREADS-1:0] fl_vld;
  logic [QCW-1:0]         walk_i;
  logic [QAW-1:0]         walk_ptr;
  logic [ID_W-1:0]        best;
  logic [PRI_W-1:0]       best_prio;
  logic                   found;
  logic [ID_W-1:0]        cur_q;
  logic [ID_W-1:0]        target;
  logic [ST_W-1:0]        rep_st;
  logic [ID_W-1:0]        rep_id;

  // request payload
  logic [MODE_W-1:0]  req_mode;
  logic [ENTRY_W-1:0] req_entry;
  logic [ARG_W-1:0]   req_arg;
  logic [DLY_W-1:0]   req_dly;

  // memory ports
  logic              info_we, info_re, dly_we, dly_re, pri_we, pri_re;
  logic              rq_we, rq_re, fl_we, fl_re;
  logic [SW-1:0]     info_wa, info_ra, dly_wa, dly_ra, pri_wa, pri_ra;
  logic [SW-1:0]     fl_wa, fl_ra, fl_wd, fl_rd;
  logic [QAW-1:0]    rq_wa, rq_ra;
  logic [ID_W-1:0]   rq_wd, rq_rd;
  logic [IW-1:0]     info_wd, info_rd;
  logic [DLY_W-1:0]  dly_wd, dly_rd;
  logic [PRI_W-1:0]  pri_wd, pri_rd;

  function automatic logic [QAW-1:0] q_add(input logic [QAW-1:0] a,
                                           input logic [QCW-1:0] b);
    logic [QCW:0] s;
    s = (QCW+1)'(a) + (QCW+1)'(b);
    if (s >= (QCW+1)'(QD)) s = s - (QCW+1)'(QD);
    return s[QAW-1:0];
  endfunction

  function automatic logic [SW-1:0] f_add(input logic [SW-1:0] a,
                                          input logic [FCW-1:0] b);
    logic [FCW:0] s;
    s = (FCW+1)'(a) + (FCW+1)'(b);
    if (s >= (FCW+1)'(MAX_THREADS)) s = s - (FCW+1)'(MAX_THREADS);
    return s[SW-1:0];
  endfunction

  function automatic logic [PRI_W-1:0] sat_inc(input logic [PRI_W-1:0] p);
    return (p == PRI_MAX) ? p : p + PRI_W'(1);
  endfunction

  logic              in_acc;
  logic              cur_is_slot, run_is_slot, best_is_slot;
  logic [DLY_W-1:0]  cur_dly, cur_dly_next;
  logic [PRI_W-1:0]  cur_prio;
  logic [SW-1:0]     spawn_slot;
  logic [QAW-1:0]    rq_tail;
  logic [SW-1:0]     fl_tail;

  assign in_ready     = (state == S_IDLE) && !rst;
  assign in_acc       = in_valid && in_ready;
  assign cur_is_slot  = cur_q < MAIN_ID;
  assign run_is_slot  = running_id < MAIN_ID;
  assign best_is_slot = best < MAIN_ID;
  assign rq_tail      = q_add(rq_head, rq_cnt);
  assign fl_tail      = f_add(fl_head, fl_cnt);
  assign spawn_slot   = fl_vld[fl_head] ? fl_rd : fl_head;

  // slot values of the walked thread; unspawned slots read as zero, main has no delay
  always_comb begin
    cur_dly  = '0;
    cur_prio = main_prio;
    if (cur_is_slot) begin
      cur_dly  = slot_vld[cur_q[SW-1:0]] ? dly_rd : '0;
      cur_prio = slot_vld[cur_q[SW-1:0]] ? pri_rd : '0;
    end
    cur_dly_next = (cur_dly != '0) ? cur_dly - DLY_W'(1) : cur_dly;
  end

  // memory control per state
  always_comb begin
    info_we = 1'b0; info_wa = spawn_slot; info_wd = {req_entry, req_arg};
    info_re = 1'b0; info_ra = rep_id[SW-1:0];
    dly_we  = 1'b0; dly_wa = cur_q[SW-1:0]; dly_wd = cur_dly_next;
    dly_re  = 1'b0; dly_ra = rq_rd[SW-1:0];
    pri_we  = 1'b0; pri_wa = cur_q[SW-1:0]; pri_wd = sat_inc(cur_prio);
    pri_re  = 1'b0; pri_ra = rq_rd[SW-1:0];
    rq_we   = 1'b0; rq_wa = rq_tail; rq_wd = running_id;
    rq_re   = 1'b0; rq_ra = walk_ptr;
    fl_we   = 1'b0; fl_wa = fl_tail; fl_wd = running_id[SW-1:0];
    fl_re   = 1'b0; fl_ra = fl_head;
    case (state)
      S_IDLE: begin
        // tick resets the running slot's priority to one
        if (in_acc && mode == MODE_TICK && run_is_slot) begin
          pri_we = 1'b1;
          pri_wa = running_id[SW-1:0];
          pri_wd = PRI_W'(1);
        end
      end
      S_SP_RD: fl_re = 1'b1;
      S_SP_WR: begin
        info_we = 1'b1;
        dly_we  = 1'b1; dly_wa = spawn_slot; dly_wd = req_dly;
        pri_we  = 1'b1; pri_wa = spawn_slot; pri_wd = PRI_W'(1);
        rq_we   = 1'b1; rq_wd = ID_W'(spawn_slot);
      end
      S_W_RDQ: rq_re = (walk_i != rq_cnt);
      S_W_RDS: begin
        dly_re = rq_rd < MAIN_ID;
        pri_re = rq_rd < MAIN_ID;
      end
      S_W_UPD: begin
        if (req_mode == MODE_TICK) begin
          dly_we = cur_is_slot && (cur_dly != '0);
          if (cur_dly_next == '0) begin
            if (cur_prio > best_prio) begin
              pri_we = best_is_slot;
              pri_wa = best[SW-1:0];
              pri_wd = sat_inc(best_prio);
            end else begin
              pri_we = cur_is_slot;
            end
          end
        end
      end
      S_W_END: begin
        if (req_mode == MODE_TICK) begin
          rq_we = (best != running_id);
        end else begin
          fl_we = found;
        end
      end
      S_ROT_RD: begin
        rq_re = 1'b1;
        rq_ra = rq_head;
      end
      S_ROT_CHK: begin
        rq_we = (rq_rd != target);
        rq_wd = rq_rd;
      end
      S_REP_RD: info_re = rep_id < MAIN_ID;
      default: ;
    endcase
  end

  // sequencer, queue pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      running_id <= MAIN_ID;
      main_prio  <= '0;
      rq_head    <= '0;
      rq_cnt     <= '0;
      fl_head    <= '0;
      fl_cnt     <= FCW'(MAX_THREADS);
      slot_vld   <= '0;
      fl_vld     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_REP_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            req_mode  <= mode;
            req_entry <= entry_point;
            req_arg   <= argument;
            req_dly   <= start_delay;
            rep_id    <= running_id;
            walk_i    <= '0;
            walk_ptr  <= rq_head;
            found     <= 1'b0;
            best      <= running_id;
            best_prio <= run_is_slot ? PRI_W'(1) : '0;
            case (mode)
              MODE_SPAWN: begin
                if (fl_cnt == '0) begin
                  rep_st <= ST_NO_FREE;
                  state  <= S_REP_RD;
                end else begin
                  rep_st <= ST_NO_SWITCH;
                  state  <= S_SP_RD;
                end
              end
              MODE_TICK: begin
                if (!run_is_slot) main_prio <= '0;
                rep_st <= ST_NO_SWITCH;
                state  <= S_W_RDQ;
              end
              MODE_EXIT: begin
                if (!run_is_slot) begin
                  rep_st <= ST_MAIN_EXIT;
                  state  <= S_REP_RD;
                end else begin
                  rep_st <= ST_NO_SWITCH;
                  state  <= S_W_RDQ;
                end
              end
              default: begin
                rep_st <= ST_NO_SWITCH;
                state  <= S_REP_RD;
              end
            endcase
          end
        end
        S_SP_RD: state <= S_SP_WR;
        S_SP_WR: begin
          slot_vld[spawn_slot] <= 1'b1;
          fl_head <= f_add(fl_head, FCW'(1));
          fl_cnt  <= fl_cnt - FCW'(1);
          rq_cnt  <= rq_cnt + QCW'(1);
          rep_id  <= ID_W'(spawn_slot);
          state   <= S_REP_RD;
        end
        S_W_RDQ: begin
          state <= (walk_i == rq_cnt) ? S_W_END : S_W_RDS;
        end
        S_W_RDS: begin
          cur_q <= rq_rd;
          state <= S_W_UPD;
        end
        S_W_UPD: begin
          if (req_mode == MODE_TICK) begin
            if (cur_dly_next == '0) begin
              if (cur_prio > best_prio) begin
                if (!best_is_slot) main_prio <= sat_inc(best_prio);
                best      <= cur_q;
                best_prio <= cur_prio;
              end else if (!cur_is_slot) begin
                main_prio <= sat_inc(cur_prio);
              end
            end
          end else if (cur_dly == '0 && (!found || cur_prio > best_prio)) begin
            best      <= cur_q;
            best_prio <= cur_prio;
            found     <= 1'b1;
          end
          walk_i   <= walk_i + QCW'(1);
          walk_ptr <= q_add(walk_ptr, QCW'(1));
          state    <= S_W_RDQ;
        end
        S_W_END: begin
          target <= best;
          if (req_mode == MODE_TICK) begin
            if (best == running_id) begin
              state <= S_REP_RD;
            end else begin
              rq_cnt <= rq_cnt + QCW'(1);
              state  <= S_ROT_RD;
            end
          end else if (!found) begin
            rep_st <= ST_NONE_RDY;
            state  <= S_REP_RD;
          end else begin
            fl_vld[fl_tail] <= 1'b1;
            fl_cnt <= fl_cnt + FCW'(1);
            state  <= S_ROT_RD;
          end
        end
        S_ROT_RD: state <= S_ROT_CHK;
        S_ROT_CHK: begin
          rq_head <= q_add(rq_head, QCW'(1));
          if (rq_rd == target) begin
            rq_cnt     <= rq_cnt - QCW'(1);
            running_id <= rq_rd;
            rep_id     <= rq_rd;
            rep_st     <= ST_SWITCHED;
            state      <= S_REP_RD;
          end else begin
            state <= S_ROT_RD;
          end
        end
        S_REP_RD: state <= S_REP_OUT;
        S_REP_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= rep_st;
            thread_id   <= rep_id;
            run_is_main <= (rep_id >= MAIN_ID);
            run_entry   <= (rep_id < MAIN_ID) ? info_rd[IW-1:ARG_W] : '0;
            run_arg     <= (rep_id < MAIN_ID) ? info_rd[ARG_W-1:0] : '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // slot entry and argument
  apts_ram #(.W(IW), .D(MAX_THREADS)) u_info (
    .clk(clk), .we(info_we), .waddr(info_wa), .wdata(info_wd),
    .re(info_re), .raddr(info_ra), .rdata(info_rd)
  );

  // slot start delays
  apts_ram #(.W(DLY_W), .D(MAX_THREADS)) u_dly (
    .clk(clk), .we(dly_we), .waddr(dly_wa), .wdata(dly_wd),
    .re(dly_re), .raddr(dly_ra), .rdata(dly_rd)
  );

  // slot priorities
  apts_ram #(.W(PRI_W), .D(MAX_THREADS)) u_pri (
    .clk(clk), .we(pri_we), .waddr(pri_wa), .wdata(pri_wd),
    .re(pri_re), .raddr(pri_ra), .rdata(pri_rd)
  );

  // ready queue ring
  apts_ram #(.W(ID_W), .D(QD)) u_rq (
    .clk(clk), .we(rq_we), .waddr(rq_wa), .wdata(rq_wd),
    .re(rq_re), .raddr(rq_ra), .rdata(rq_rd)
  );

  // free list ring
  apts_ram #(.W(SW), .D(MAX_THREADS)) u_fl (
    .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd),
    .re(fl_re), .raddr(fl_ra), .rdata(fl_rd)
  );

endmodule

### hw/rtl/apts_ram.sv
module apts_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
